/* design/pidtp_pkg.sv */
// Package: shared types and constants for the per-ID execution time profiler.
`timescale 1ns / 1ps
`default_nettype none
package pidtp_pkg;

	localparam int NUM_RECORDS = 32;
	localparam int TIMER_BITS  = 32;
	localparam int IDX_W       = (NUM_RECORDS > 1) ? $clog2(NUM_RECORDS) : 1;
	localparam logic [31:0] TIMER_MASK = 32'((64'd1 << TIMER_BITS) - 64'd1);
	localparam int CFG_IDX_W   = 1;

	typedef enum logic [1:0] {
		FN_START = 2'd0,
		FN_STOP  = 2'd1,
		FN_READ  = 2'd2,
		FN_CLEAR = 2'd3
	} func_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COUNT_DOWN = 1'b0,
		REG_TIMER_TOP  = 1'b1
	} cfg_reg_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_UPDATE
	} ctrl_state_e;

	typedef struct packed {
		func_e       func;
		logic [4:0]  entry_id;
		logic [31:0] timestamp;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] elapsed;
		logic [63:0] total_ticks;
		logic [31:0] longest;
		logic [31:0] shortest;
		logic [31:0] stop_count;
	} out_beat_t;

	typedef struct packed {
		logic [31:0] stamp;
		logic [63:0] sum;
		logic [31:0] longest;
		logic [31:0] shortest;
		logic [31:0] stops;
	} record_t;

	typedef struct packed {
		logic count_down;
		logic [31:0] timer_top;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic calc;
		logic update;
	} dp_cmd_t;

endpackage
`default_nettype wire

/* design/pidtp_cfg.sv */
// Configuration registers: timer direction and timer top value.
`timescale 1ns / 1ps
`default_nettype none
module pidtp_cfg
	import pidtp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	output cfg_t                      cfg
);

	logic        count_down_q;
	logic [31:0] timer_top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_down_q <= 1'b0;
			timer_top_q  <= 32'hFFFF_FFFF;
		end else if (cfg_valid) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_COUNT_DOWN: count_down_q <= cfg_data[0];
				REG_TIMER_TOP:  timer_top_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.count_down = count_down_q;
	assign cfg.timer_top  = timer_top_q & TIMER_MASK;

endmodule
`default_nettype wire

/* design/pidtp_ctrl.sv */
// Controller: sequences capture, elapsed calculation and record update per beat.
`timescale 1ns / 1ps
`default_nettype none
module pidtp_ctrl
	import pidtp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	output dp_cmd_t   cmd
);

	ctrl_state_e state_q, state_d;
	logic        out_full_q, out_full_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			out_full_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			out_full_q <= out_full_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_stall    = 1'b1;
		out_full_d  = out_full_q && out_stall;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (!out_full_q || !out_stall) begin
					cmd.update = 1'b1;
					out_full_d = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_full_q;

endmodule
`default_nettype wire

/* design/pidtp_dp.sv */
// Datapath: record table, elapsed-time calculation, statistics update, result register.
`timescale 1ns / 1ps
`default_nettype none
module pidtp_dp
	import pidtp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_beat_t in_data,
	input  wire cfg_t     cfg,
	input  wire dp_cmd_t  cmd,
	output out_beat_t     out_data
);

	record_t                mem [NUM_RECORDS];
	logic [NUM_RECORDS-1:0] vld_q;

	func_e       func_q;
	logic [IDX_W-1:0] idx_q;
	logic [31:0] now_q;
	logic        hit_q;
	record_t     rec_q;
	logic        rec_vld_q;
	logic [31:0] el_q;
	out_beat_t   res_q;

	logic [IDX_W-1:0] in_idx;
	record_t     base;
	logic [31:0] op_a, op_b, el_d;
	record_t     upd;
	logic        wr_en;
	out_beat_t   res_d;

	assign in_idx = IDX_W'(in_data.entry_id);
	assign base   = rec_vld_q ? rec_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q    <= in_data.func;
			idx_q     <= in_idx;
			now_q     <= in_data.timestamp & TIMER_MASK;
			hit_q     <= (int'(in_data.entry_id) < NUM_RECORDS);
			rec_q     <= mem[in_idx];
		end
		if (cmd.calc) begin
			el_q <= el_d;
		end
		if (cmd.update) begin
			res_q <= res_d;
		end
		if (wr_en) begin
			mem[idx_q] <= upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rec_vld_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				rec_vld_q <= vld_q[in_idx];
			end
			if (cmd.update && func_q == FN_CLEAR) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[idx_q] <= 1'b1;
			end
		end
	end

	always_comb begin
		op_a = cfg.count_down ? base.stamp : now_q;
		op_b = cfg.count_down ? now_q : base.stamp;
		if (op_a > op_b) begin
			el_d = op_a - op_b;
		end else begin
			el_d = cfg.timer_top - op_b + 32'd1 + op_a;
		end
	end

	always_comb begin
		upd   = base;
		wr_en = 1'b0;
		res_d = '0;
		if (func_q != FN_CLEAR && hit_q) begin
			unique case (func_q)
				FN_START: begin
					upd.stamp = now_q;
					wr_en     = cmd.update;
				end
				FN_STOP: begin
					upd.stops = base.stops + 32'd1;
					upd.sum   = base.sum + 64'(el_q);
					if (el_q > base.longest) begin
						upd.longest = el_q;
					end
					if (el_q < base.shortest || base.shortest == 32'd0) begin
						upd.shortest = el_q;
					end
					wr_en         = cmd.update;
					res_d.elapsed = el_q;
				end
				default: ;
			endcase
			res_d.total_ticks = upd.sum;
			res_d.longest     = upd.longest;
			res_d.shortest    = upd.shortest;
			res_d.stop_count  = upd.stops;
		end
	end

	assign out_data = res_q;

endmodule
`default_nettype wire

/* design/per_id_execution_time_profiler_top.sv */
// Top level of the per-ID execution time profiler.
//
//   channel  direction  handshake             beat
//   in       to block   in_valid / in_stall   in_beat_t (func, entry_id, timestamp)
//   out      from block out_valid / out_stall out_beat_t (elapsed, record fields)
//   cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each beat goes through capture with table read, elapsed calculation, and
// record update with table write. The next beat is taken once the update is done.
// The result register holds one finished beat while the next one is processed.
// The update waits while the result register is full and out_stall is high.
// Reset clears all records at once through per-record valid bits; clear does the same.
// cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module per_id_execution_time_profiler_top
	import pidtp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_beat_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_beat_t                 out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	cfg_t    cfg;
	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	pidtp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidtp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	pidtp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg      (cfg),
		.cmd      (cmd),
		.out_data (out_data)
	);

endmodule
`default_nettype wire
